[rtl/tsr_pkg.sv]
// Shared types and constants for the tilemap scroll refresh unit.
// Depends on nothing; every other file in rtl/ but tsr_fifo refers to it by scoped names.
`default_nettype none

package tsr_pkg;

   // Opcodes of the request channel.
   localparam logic [1:0] OP_SET_POS  = 2'd0;
   localparam logic [1:0] OP_SCROLL_H = 2'd1;
   localparam logic [1:0] OP_SCROLL_V = 2'd2;

   // Register indexes of the configuration port.
   localparam logic CSR_MAP_WIDTH  = 1'b0;
   localparam logic CSR_MAP_HEIGHT = 1'b1;

   // View geometry, in pixels and in tiles.
   localparam int VIEW_OFF_X = 120;
   localparam int VIEW_OFF_Y = 80;
   localparam int H_ROWS     = 23;
   localparam int V_COLS     = 31;
   localparam int H_LEAD     = 31;
   localparam int H_NEXT     = 30;
   localparam int V_LEAD     = 20;
   localparam int V_NEXT     = 19;

   // Queue sizes.
   localparam int CMD_DEPTH = 2;
   localparam int OUT_DEPTH = 4;
   localparam int OUT_CNT_W = 3;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [15:0] position_x;
      logic signed [15:0] position_y;
      logic signed [7:0]  delta;
   } req_type;

   typedef struct packed {
      logic [7:0]  scroll_x_reg;
      logic [7:0]  scroll_y_reg;
      logic [9:0]  vram_index;
      logic [19:0] map_offset;
      logic        in_bounds;
      logic        last;
   } rsp_type;

   // One classified scroll command, handed from the front to the back.
   typedef struct packed {
      logic               vertical;
      logic               forward;
      logic [7:0]         sx;
      logic [7:0]         sy;
      logic signed [13:0] bx;
      logic signed [13:0] by;
   } cmd_type;

endpackage

`default_nettype wire

[rtl/tsr_fifo.sv]
// Small synchronous queue of flip-flops with a push and a pop side.
// Depends on nothing; DEPTH must be a power of two.
`default_nettype none

module tsr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           push_data,
   input  wire logic                       pop,
   output logic [WIDTH-1:0]                pop_data,
   output logic                            full,
   output logic                            empty,
   output logic [$clog2(DEPTH+1)-1:0]      count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/tsr_front.sv]
// Front end: keeps the camera position and turns scroll requests into commands.
// Depends on tsr_pkg.
`default_nettype none

module tsr_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_accept,
   input  wire tsr_pkg::req_type req_data,
   output logic                  cmd_push,
   output tsr_pkg::cmd_type      cmd_data
);

   logic [15:0]        camera_x_ff, camera_x_in;
   logic [15:0]        camera_y_ff, camera_y_in;
   logic               rem_neg;
   logic signed [3:0]  rem;
   logic [15:0]        rem_ext;
   logic signed [16:0] left;
   logic signed [16:0] top;
   logic               is_h;
   logic               is_v;

   // Truncating remainder by 8: the sign follows the delta.
   assign rem_neg = req_data.delta[7] && (req_data.delta[2:0] != 3'd0);
   assign rem     = {rem_neg, req_data.delta[2:0]};
   assign rem_ext = {{12{rem[3]}}, rem};
   assign is_h    = (req_data.opcode == tsr_pkg::OP_SCROLL_H);
   assign is_v    = (req_data.opcode == tsr_pkg::OP_SCROLL_V);

   always_comb begin
      camera_x_in = camera_x_ff;
      camera_y_in = camera_y_ff;
      if (req_accept) begin
         if (req_data.opcode == tsr_pkg::OP_SET_POS) begin
            camera_x_in = req_data.position_x;
            camera_y_in = req_data.position_y;
         end else if (is_h) begin
            camera_x_in = camera_x_ff + rem_ext;
         end else if (is_v) begin
            camera_y_in = camera_y_ff + rem_ext;
         end
      end
   end

   // The command sees the position after this request.
   assign left = $signed({camera_x_in[15], camera_x_in}) - 17'sd120;
   assign top  = $signed({camera_y_in[15], camera_y_in}) - 17'sd80;

   assign cmd_push          = req_accept && (is_h || is_v);
   assign cmd_data.vertical = is_v;
   assign cmd_data.forward  = !rem_neg;
   assign cmd_data.sx       = left[7:0];
   assign cmd_data.sy       = top[7:0];
   assign cmd_data.bx       = left[16:3];
   assign cmd_data.by       = top[16:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         camera_x_ff <= 16'(tsr_pkg::VIEW_OFF_X);
         camera_y_ff <= 16'(tsr_pkg::VIEW_OFF_Y);
      end else begin
         camera_x_ff <= camera_x_in;
         camera_y_ff <= camera_y_in;
      end
   end

endmodule

`default_nettype wire

[rtl/tsr_back.sv]
// Back end: sequences the copy orders of one command and computes each order.
// Depends on tsr_pkg; feeds the result queue instantiated by the top level.
`default_nettype none

module tsr_back #(
   parameter int MAP_SIDE_MAX = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [10:0]                map_width_tiles,
   input  wire logic [10:0]                map_height_tiles,
   input  wire tsr_pkg::cmd_type           cmd_data,
   input  wire logic                       cmd_empty,
   output logic                            cmd_pop,
   input  wire logic [tsr_pkg::OUT_CNT_W-1:0] out_count,
   output logic                            out_push,
   output tsr_pkg::rsp_type                out_data
);

   localparam logic [12:0] SIDE_LIMIT = 13'(MAP_SIDE_MAX);

   typedef struct packed {
      logic [7:0]         sx;
      logic [7:0]         sy;
      logic [9:0]         idx;
      logic signed [14:0] tx;
      logic signed [14:0] ty;
      logic               last;
   } ord_type;

   // Sequencer state.
   logic             busy_ff, busy_in;
   tsr_pkg::cmd_type cmd_ff, cmd_in;
   logic [5:0]       step_ff, step_in;

   // Pipeline stages.
   logic             valid_a_ff, valid_a_in;
   ord_type          ord_a_ff, ord_a_in;
   logic             valid_b_ff;
   tsr_pkg::rsp_type rsp_b_ff, rsp_b_in;

   logic [4:0]  pair;
   logic        sub;
   logic [4:0]  cross_off;
   logic [4:0]  row_off;
   logic [4:0]  col_off;
   logic        last_pair;
   logic        step_last;
   logic [3:0]  pending;
   logic        issue;
   logic        load;
   logic [10:0] w_sat;
   logic [10:0] h_sat;
   logic        inb;
   logic [21:0] product;
   logic [21:0] offset;

   // Saturate oversized maps.
   assign w_sat = ({2'b00, map_width_tiles} > SIDE_LIMIT) ? 11'(MAP_SIDE_MAX) : map_width_tiles;
   assign h_sat = ({2'b00, map_height_tiles} > SIDE_LIMIT) ? 11'(MAP_SIDE_MAX) : map_height_tiles;

   // Order generation: step = 2 * pair + sub.
   assign pair = step_ff[5:1];
   assign sub  = step_ff[0];

   always_comb begin
      priority if (cmd_ff.vertical) begin
         cross_off = cmd_ff.forward ? (sub ? 5'(tsr_pkg::V_NEXT) : 5'(tsr_pkg::V_LEAD))
                                    : (sub ? 5'd1 : 5'd0);
         row_off   = cross_off;
         col_off   = pair;
         last_pair = (pair == 5'(tsr_pkg::V_COLS - 1));
      end else begin
         cross_off = cmd_ff.forward ? (sub ? 5'(tsr_pkg::H_NEXT) : 5'(tsr_pkg::H_LEAD))
                                    : (sub ? 5'd1 : 5'd0);
         row_off   = pair;
         col_off   = cross_off;
         last_pair = (pair == 5'(tsr_pkg::H_ROWS - 1));
      end
   end

   assign step_last = sub && last_pair;

   // Issue only when every order in flight has a slot in the result queue.
   assign pending = 4'(out_count) + 4'(valid_a_ff) + 4'(valid_b_ff);
   assign issue   = busy_ff && (pending < 4'(tsr_pkg::OUT_DEPTH));
   assign load    = !cmd_empty && (!busy_ff || (issue && step_last));
   assign cmd_pop = load;

   always_comb begin
      busy_in = busy_ff;
      cmd_in  = cmd_ff;
      step_in = step_ff;
      if (load) begin
         busy_in = 1'b1;
         cmd_in  = cmd_data;
         step_in = '0;
      end else if (issue) begin
         if (step_last) begin
            busy_in = 1'b0;
         end else begin
            step_in = 6'(step_ff + 1'b1);
         end
      end
   end

   always_comb begin
      valid_a_in    = issue;
      ord_a_in.sx   = cmd_ff.sx;
      ord_a_in.sy   = cmd_ff.sy;
      ord_a_in.idx  = {5'(cmd_ff.sy[7:3] + row_off), 5'(cmd_ff.sx[7:3] + col_off)};
      ord_a_in.tx   = 15'(cmd_ff.bx) + $signed({10'd0, col_off});
      ord_a_in.ty   = 15'(cmd_ff.by) + $signed({10'd0, row_off});
      ord_a_in.last = step_last;
   end

   // Bounds check and source offset.
   assign inb = !ord_a_ff.tx[14] && !ord_a_ff.ty[14]
                && (ord_a_ff.tx[13:0] < {3'b000, w_sat})
                && (ord_a_ff.ty[13:0] < {3'b000, h_sat});
   assign product = ord_a_ff.ty[10:0] * w_sat;
   assign offset  = product + {11'd0, ord_a_ff.tx[10:0]};

   always_comb begin
      rsp_b_in.scroll_x_reg = ord_a_ff.sx;
      rsp_b_in.scroll_y_reg = ord_a_ff.sy;
      rsp_b_in.vram_index   = ord_a_ff.idx;
      rsp_b_in.map_offset   = inb ? offset[19:0] : 20'd0;
      rsp_b_in.in_bounds    = inb;
      rsp_b_in.last         = ord_a_ff.last;
   end

   assign out_push = valid_b_ff;
   assign out_data = rsp_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         step_ff    <= '0;
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         step_ff    <= step_in;
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      ord_a_ff <= ord_a_in;
      rsp_b_ff <= rsp_b_in;
   end

   // The credit check must keep the result queue from overflowing.
   assert property (@(posedge clock) disable iff (reset)
      out_push |-> (out_count < tsr_pkg::OUT_CNT_W'(tsr_pkg::OUT_DEPTH)))
      else $error("order pushed into a full result queue");

   // A new command is taken only when idle or on the final order of the current one.
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (!busy_ff || (issue && step_last)))
      else $error("command loaded while another is still in progress");

   // An order issued as the final one reaches the output through the pipeline stages, flagged last.
   assert property (@(posedge clock) disable iff (reset)
      (issue && step_last) |=> ##1 (out_push && out_data.last))
      else $error("final order lost its last flag in the pipeline");

endmodule

`default_nettype wire

[rtl/tilemap_scroll_refresh_unit.sv]
// Top level of the tilemap scroll refresh unit: front end, command queue,
// back end and result queue. Depends on tsr_pkg, tsr_fifo, tsr_front, tsr_back.
`default_nettype none

// The unit keeps a camera position and, for each scroll request, streams the
// tile copy orders that refresh a 32x32 ring tile map. A set-position request
// loads the camera and produces nothing. A horizontal scroll produces 46
// orders and a vertical scroll 62, at one order per cycle while the consumer
// keeps popping: the order sequencer in the back end issues one order per
// cycle while the result queue has room for it and the orders in flight. On
// its way to the result side, each order passes the pipeline stages of the
// back end. The front end classifies requests, and scroll commands wait in a
// two-entry command queue, so further requests are taken while the back end
// is still streaming; the request side reports full only when that queue is.
// Results wait in a four-entry queue, which lets the consumer stall at any
// time without losing an order. Every result carries the scroll register
// values after its request, and the final order of a request has last set.
// Map width and height registers may be written only while the unit is idle;
// values above MAP_SIDE_MAX are treated as MAP_SIDE_MAX.
module tilemap_scroll_refresh_unit #(
   parameter int MAP_SIDE_MAX = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // Request channel.
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire tsr_pkg::req_type req_data,
   // Result channel.
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output tsr_pkg::rsp_type      rsp_data,
   // Configuration port.
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [10:0]      csr_wdata
);

   localparam int CMD_W = $bits(tsr_pkg::cmd_type);
   localparam int RSP_W = $bits(tsr_pkg::rsp_type);

   logic [10:0]      map_width_tiles_ff;
   logic [10:0]      map_height_tiles_ff;
   logic             req_accept;
   logic             cmd_push;
   tsr_pkg::cmd_type cmd_push_data;
   tsr_pkg::cmd_type cmd_pop_data;
   logic             cmd_pop;
   logic             cmd_full;
   logic             cmd_empty;
   logic [$clog2(tsr_pkg::CMD_DEPTH+1)-1:0] cmd_count;
   logic             out_push;
   tsr_pkg::rsp_type out_data;
   logic             out_full;
   logic [tsr_pkg::OUT_CNT_W-1:0] out_count;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_tiles_ff  <= 11'd32;
         map_height_tiles_ff <= 11'd32;
      end else if (csr_we) begin
         unique case (csr_index)
            tsr_pkg::CSR_MAP_WIDTH:  map_width_tiles_ff  <= csr_wdata;
            tsr_pkg::CSR_MAP_HEIGHT: map_height_tiles_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A request transfer happens whenever the command queue has room.
   assign req_full   = cmd_full;
   assign req_accept = req_push && !cmd_full;

   tsr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_push_data)
   );

   tsr_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (tsr_pkg::CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .pop       (cmd_pop),
      .pop_data  (cmd_pop_data),
      .full      (cmd_full),
      .empty     (cmd_empty),
      .count     (cmd_count)
   );

   tsr_back #(
      .MAP_SIDE_MAX (MAP_SIDE_MAX)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .map_width_tiles  (map_width_tiles_ff),
      .map_height_tiles (map_height_tiles_ff),
      .cmd_data         (cmd_pop_data),
      .cmd_empty        (cmd_empty),
      .cmd_pop          (cmd_pop),
      .out_count        (out_count),
      .out_push         (out_push),
      .out_data         (out_data)
   );

   // The result queue is never full when the back end pushes, by its credit check.
   tsr_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (tsr_pkg::OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .full      (out_full),
      .empty     (rsp_empty),
      .count     (out_count)
   );

   // When the command queue is full, its count equals its depth.
   assert property (@(posedge clock) disable iff (reset)
      cmd_full |-> (cmd_count == 2'(tsr_pkg::CMD_DEPTH)))
      else $error("command queue count out of range");

   // The result queue is full only when its count says so.
   assert property (@(posedge clock) disable iff (reset)
      out_full |-> (out_count == tsr_pkg::OUT_CNT_W'(tsr_pkg::OUT_DEPTH)))
      else $error("result queue full flag disagrees with its count");

   // A scroll request transfer always reaches the command queue.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && ((req_data.opcode == tsr_pkg::OP_SCROLL_H)
                      || (req_data.opcode == tsr_pkg::OP_SCROLL_V))) |-> cmd_push)
      else $error("scroll request dropped by the front end");

endmodule

`default_nettype wire

[dv/tilemap_scroll_refresh_unit_tb.sv]
// Self-checking testbench for tilemap_scroll_refresh_unit: predicts every tile copy order
// and compares it with the result queue. Depends on tsr_pkg and the unit's RTL only.
`default_nettype none

module tilemap_scroll_refresh_unit_tb;

   // The package names three opcodes; the fourth encoding is ignored by the unit.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Columns (or rows) refreshed when the camera moves toward the origin.
   localparam int BACK_LEAD = 0;
   localparam int BACK_NEXT = 1;

   localparam int MAP_SIDE_MAX = 1024;
   localparam int RING_BITS    = 5;

   // Cycles without any transfer before the run is declared hung. The longest
   // legitimate quiet stretch is the deliberate consumer hold of HOLD_CYCLES.
   localparam int QUIET_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_CYCLES = 24;

   localparam int NUM_PHASES = 6;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   tsr_pkg::req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   tsr_pkg::rsp_type rsp_data;
   logic    csr_we;
   logic    csr_index;
   logic [10:0] csr_wdata;

   tilemap_scroll_refresh_unit #(
      .MAP_SIDE_MAX(MAP_SIDE_MAX)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Predictor state: the camera position and the two map size registers, kept
   // exactly as wide as the unit keeps them.
   logic [15:0] cam_x;
   logic [15:0] cam_y;
   logic [10:0] map_w;
   logic [10:0] map_h;

   // Requests still to be offered, and copy orders predicted but not yet seen.
   tsr_pkg::req_type pending_cmds[$];
   tsr_pkg::rsp_type expected_orders[$];

   int  fail_count;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  quiet_cycles;
   bit  drive_on;
   bit  req_taken;
   bit  hold_go;
   bit  pop_hold;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // A size register above MAP_SIDE_MAX behaves as MAP_SIDE_MAX.
   function automatic int clamp_side(logic [10:0] side);
      return (side > MAP_SIDE_MAX) ? MAP_SIDE_MAX : int'(side);
   endfunction

   // Appends one copy order. Ring coordinates wrap at 32; a source tile outside
   // the map carries a zero offset and a cleared in-bounds flag.
   function automatic void add_copy_order(logic [7:0] sx, logic [7:0] sy, int ring_row,
                                          int ring_col, int tx, int ty, bit is_last);
      tsr_pkg::rsp_type order;
      int      w;
      int      h;
      bit      in_map;
      w = clamp_side(map_w);
      h = clamp_side(map_h);
      in_map = (tx >= 0) && (ty >= 0) && (tx < w) && (ty < h);
      order.scroll_x_reg = sx;
      order.scroll_y_reg = sy;
      order.vram_index   = {ring_row[RING_BITS-1:0], ring_col[RING_BITS-1:0]};
      order.map_offset   = in_map ? 20'(ty * w + tx) : 20'd0;
      order.in_bounds    = in_map;
      order.last         = is_last;
      expected_orders.push_back(order);
   endfunction

   // Advances the camera for one accepted request and queues the copy orders
   // that the request should produce.
   function automatic void predict_scroll(tsr_pkg::req_type cmd);
      int rem;
      int left;
      int top;
      int bx;
      int by;
      int lead;
      int next;
      int rx;
      int ry;
      logic [7:0] sx;
      logic [7:0] sy;
      case (cmd.opcode)
         tsr_pkg::OP_SET_POS: begin
            cam_x = cmd.position_x;
            cam_y = cmd.position_y;
            return;
         end
         tsr_pkg::OP_SCROLL_H, tsr_pkg::OP_SCROLL_V: ;
         default: return;
      endcase

      // Remainder truncates toward zero, so its sign follows the delta.
      rem = $signed(cmd.delta) % 8;
      if (cmd.opcode == tsr_pkg::OP_SCROLL_H)
         cam_x = cam_x + 16'(rem);
      else
         cam_y = cam_y + 16'(rem);

      left = int'($signed(cam_x)) - tsr_pkg::VIEW_OFF_X;
      top  = int'($signed(cam_y)) - tsr_pkg::VIEW_OFF_Y;
      sx   = left[7:0];
      sy   = top[7:0];
      rx   = int'(sx[7:3]);
      ry   = int'(sy[7:3]);
      // Arithmetic shift of a signed int rounds toward minus infinity.
      bx   = left >>> 3;
      by   = top >>> 3;

      if (cmd.opcode == tsr_pkg::OP_SCROLL_H) begin
         lead = (rem >= 0) ? tsr_pkg::H_LEAD : BACK_LEAD;
         next = (rem >= 0) ? tsr_pkg::H_NEXT : BACK_NEXT;
         for (int i = 0; i < tsr_pkg::H_ROWS; i++) begin
            add_copy_order(sx, sy, ry + i, rx + lead, bx + lead, by + i, 1'b0);
            add_copy_order(sx, sy, ry + i, rx + next, bx + next, by + i,
                           i == tsr_pkg::H_ROWS - 1);
         end
      end else begin
         lead = (rem >= 0) ? tsr_pkg::V_LEAD : BACK_LEAD;
         next = (rem >= 0) ? tsr_pkg::V_NEXT : BACK_NEXT;
         for (int i = 0; i < tsr_pkg::V_COLS; i++) begin
            add_copy_order(sx, sy, ry + lead, rx + i, bx + i, by + lead, 1'b0);
            add_copy_order(sx, sy, ry + next, rx + i, bx + i, by + next,
                           i == tsr_pkg::V_COLS - 1);
         end
      end
   endfunction

   function automatic tsr_pkg::req_type make_req(logic [1:0] op, int px, int py, int d);
      tsr_pkg::req_type r;
      r.opcode     = op;
      r.position_x = 16'(px);
      r.position_y = 16'(py);
      r.delta      = 8'(d);
      return r;
   endfunction

   // Camera coordinates are drawn from four regions: anywhere, around the mapped
   // area of the current size (so tiles straddle the edges), around the 16-bit
   // wrap point, and around zero.
   function automatic int random_coord(int view_off, int side);
      case ($urandom_range(3))
         0:       return int'($urandom_range(0, 65535));
         1:       return view_off + int'($urandom_range(0, 8 * side + 512)) - 256;
         2:       return 32768 + int'($urandom_range(0, 400)) - 200;
         default: return int'($urandom_range(0, 400)) - 200;
      endcase
   endfunction

   function automatic tsr_pkg::req_type random_request();
      tsr_pkg::req_type r;
      int      sel;
      sel = $urandom_range(99);
      r.position_x = 16'(random_coord(tsr_pkg::VIEW_OFF_X, clamp_side(map_w)));
      r.position_y = 16'(random_coord(tsr_pkg::VIEW_OFF_Y, clamp_side(map_h)));
      r.delta      = 8'($urandom_range(0, 255));
      if (sel < 6)
         r.opcode = OP_UNUSED;
      else if (sel < 26)
         r.opcode = tsr_pkg::OP_SET_POS;
      else if (sel < 63)
         r.opcode = tsr_pkg::OP_SCROLL_H;
      else
         r.opcode = tsr_pkg::OP_SCROLL_V;
      return r;
   endfunction

   function automatic void check_field(string field, logic [19:0] want, logic [19:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
         fail_count++;
      end
   endfunction

   // Request driver. Inputs change on the falling edge. An offered request stays
   // on the port until it is transferred; a new offer is made at random according
   // to the current sender idle rate.
   always @(negedge clock) begin : req_driver
      bit was_taken;
      was_taken = req_taken;
      if (req_taken) begin
         void'(pending_cmds.pop_front());
         req_taken = 1'b0;
      end
      if (drive_on && pending_cmds.size() != 0 &&
          ((req_push && !was_taken) || $urandom_range(99) >= send_idle_pct)) begin
         req_push <= 1'b1;
         req_data <= pending_cmds[0];
      end else begin
         req_push <= 1'b0;
      end
   end

   // Consumer. Pop is a level; it is lowered at random, and held low for the
   // whole of a pressure stretch so that both queues in the unit fill up.
   always @(negedge clock) begin
      rsp_pop <= !pop_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // Every request transfer updates the predictor at the edge it happens on.
   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         predict_scroll(req_data);
         req_taken = 1'b1;
      end
   end

   // Every result transfer is matched against the oldest predicted copy order.
   always @(posedge clock) begin : order_checker
      tsr_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_orders.size() == 0) begin
            $display("%0t: copy order with none predicted, actual 0x%0h", $time, rsp_data);
            fail_count++;
         end else begin
            want = expected_orders.pop_front();
            check_field("scroll_x_reg", want.scroll_x_reg, rsp_data.scroll_x_reg);
            check_field("scroll_y_reg", want.scroll_y_reg, rsp_data.scroll_y_reg);
            check_field("vram_index",   want.vram_index,   rsp_data.vram_index);
            check_field("map_offset",   want.map_offset,   rsp_data.map_offset);
            check_field("in_bounds",    want.in_bounds,    rsp_data.in_bounds);
            check_field("last",         want.last,         rsp_data.last);
         end
      end
   end

   // Pressure stretch: once requested, the consumer stops popping for the length
   // of the hold while the sender keeps offering requests.
   initial begin
      pop_hold = 1'b0;
      wait (hold_go);
      @(posedge clock);
      pop_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      pop_hold = 1'b0;
   end

   // Watchdog: any transfer on either side restarts the count.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("tilemap_scroll_refresh_unit_tb: FAIL");
         $finish;
      end
   end

   // Waits until every request has been transferred and every predicted order has
   // been seen, then lets the unit settle.
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_push || expected_orders.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both size registers, one per cycle, while the unit is idle.
   task automatic write_map_size(logic [10:0] w, logic [10:0] h);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= tsr_pkg::CSR_MAP_WIDTH;
      csr_wdata <= w;
      map_w = w;
      @(negedge clock);
      csr_index <= tsr_pkg::CSR_MAP_HEIGHT;
      csr_wdata <= h;
      map_h = h;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Test sequence. Phase 0 runs at the reset map size with a directed list:
   // both scroll directions with zero, positive and negative remainders, the
   // delta extremes, camera positions that put the view wholly or partly off the
   // map, coordinates that wrap at 16 bits, and the ignored opcode. The later
   // phases move through the largest map size, a map size of one tile, oversized
   // registers that saturate, zero registers that leave every tile outside, and
   // a random size. The first two phases idle the consumer heavily, the next two
   // idle the sender heavily, and the last two run flat out with one long
   // consumer hold.
   initial begin
      int phase_items[NUM_PHASES];
      int phase_w[NUM_PHASES];
      int phase_h[NUM_PHASES];
      int counted;
      tsr_pkg::req_type r;

      phase_items = '{25, 40, 40, 30, 30, 45};
      phase_w     = '{32, 1024, 1, 2047, 0, -1};
      phase_h     = '{32, 1024, 1, 0, 2047, -1};

      reset       = 1'b1;
      req_push    = 1'b0;
      req_data    = '0;
      rsp_pop     = 1'b0;
      csr_we      = 1'b0;
      csr_index   = tsr_pkg::CSR_MAP_WIDTH;
      csr_wdata   = '0;
      fail_count  = 0;
      quiet_cycles = 0;
      drive_on    = 1'b0;
      req_taken   = 1'b0;
      hold_go     = 1'b0;
      cam_x       = 16'(tsr_pkg::VIEW_OFF_X);
      cam_y       = 16'(tsr_pkg::VIEW_OFF_Y);
      map_w       = 11'd32;
      map_h       = 11'd32;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed list at the reset camera and map size.
      pending_cmds.push_back(make_req(tsr_pkg::OP_SCROLL_H, 0, 0, 0));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SCROLL_V, 0, 0, 0));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SCROLL_H, 0, 0, 127));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SCROLL_H, 0, 0, -128));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SCROLL_H, 0, 0, -1));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SCROLL_H, 0, 0, -121));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SCROLL_V, 0, 0, 127));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SCROLL_V, 0, 0, -128));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SCROLL_V, 0, 0, -7));
      pending_cmds.push_back(make_req(OP_UNUSED, -1, -1, -1));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SET_POS, 0, 0, 0));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SCROLL_H, 0, 0, 3));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SCROLL_V, 0, 0, -5));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SET_POS, 32767, 32767, 127));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SCROLL_H, -1, -1, 7));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SCROLL_V, 0, 0, 5));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SET_POS, -32768, -32768, -128));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SCROLL_V, 0, 0, -3));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SCROLL_H, 0, 0, -2));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SET_POS, tsr_pkg::VIEW_OFF_X + 160,
                                      tsr_pkg::VIEW_OFF_Y + 160, 0));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SCROLL_H, 0, 0, 1));
      pending_cmds.push_back(make_req(tsr_pkg::OP_SCROLL_V, 0, 0, -1));
      pending_cmds.push_back(make_req(OP_UNUSED, 0, 0, 0));

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p != 0) begin
            wait_idle();
            write_map_size((phase_w[p] < 0) ? 11'($urandom_range(1, MAP_SIDE_MAX)) :
                                              11'(phase_w[p]),
                           (phase_h[p] < 0) ? 11'($urandom_range(1, MAP_SIDE_MAX)) :
                                              11'(phase_h[p]));
            @(posedge clock);
         end
         if (p < 2) begin
            send_idle_pct = 24;
            recv_idle_pct = 72;
         end else if (p < 4) begin
            send_idle_pct = 72;
            recv_idle_pct = 24;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (p == 4)
            hold_go = 1'b1;

         // Ignored requests still go out but do not count toward the phase.
         counted = 0;
         while (counted < phase_items[p]) begin
            r = random_request();
            pending_cmds.push_back(r);
            if (r.opcode != OP_UNUSED)
               counted++;
         end
         drive_on = 1'b1;
      end

      wait_idle();
      if (fail_count == 0)
         $display("tilemap_scroll_refresh_unit_tb: PASS");
      else
         $display("tilemap_scroll_refresh_unit_tb: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
